// ===== sv/cbr_pkg.sv =====
// shared constants, op codes and controller/datapath interface types
package cbr_pkg;

  localparam int unsigned BITMAP_BITS_DEF  = 65536;
  localparam int unsigned BITMAP_BYTES_DEF = 8192;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COUNT_W = 17;

  localparam logic [ID_W-1:0]    GOLDEN_STEP = 32'h9e37_79b9;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'h1_ffff;

  localparam logic [OP_W-1:0] OP_DIRECT = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd3;

  typedef struct packed {
    logic load_id;    // capture the incoming id
    logic hash_sum;   // first half of the edge mix
    logic mod_load;   // start reducing the index
    logic sel_edge;   // reduce the mixed value instead of the raw id
    logic mod_step;   // one step of the index reduction
    logic rd_en;      // read the byte holding the bit
    logic wr_bit;     // set the bit if still clear
    logic clr_start;  // rewind the sweep and zero the count
    logic clr_step;   // zero one byte
  } cbr_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic clr_last;
  } cbr_status_t;

endpackage

// ===== sv/cbr_ram.sv =====
// generic single-write, single-read ram with registered read
module cbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/cbr_dp.sv =====
// datapath: edge mix, index reduction, bitmap ram, set-bit count
module cbr_dp #(
  parameter int unsigned BITMAP_BITS  = cbr_pkg::BITMAP_BITS_DEF,
  parameter int unsigned BITMAP_BYTES = cbr_pkg::BITMAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cbr_pkg::ID_W-1:0]     in_hit_id,
  input  cbr_pkg::cbr_cmd_t            cmd,
  output cbr_pkg::cbr_status_t         status,
  output logic [cbr_pkg::COUNT_W-1:0]  out_bit_count
);

  import cbr_pkg::*;

  localparam int unsigned BIT_W  = $clog2(BITMAP_BITS);
  localparam int unsigned AW     = $clog2(BITMAP_BYTES);
  localparam int unsigned CW     = $clog2(8 * BITMAP_BYTES + 1);
  localparam int unsigned MCNT_W = 2;
  localparam bit          POW2   = (BITMAP_BITS & (BITMAP_BITS - 1)) == 0;

  localparam logic [MCNT_W-1:0] STEP_MUL = 2'd3;
  localparam logic [MCNT_W-1:0] STEP_SUB = 2'd2;
  localparam logic [MCNT_W-1:0] STEP_FIX = 2'd1;
  // floor(2^32 / BITMAP_BITS): the quotient estimate is at most one short
  localparam logic [ID_W-1:0] RECIP = ID_W'(64'h1_0000_0000 / 64'(BITMAP_BITS));

  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   prev_r, prev_nxt;
  logic [ID_W-1:0]   s1_r, s1_nxt;
  logic [ID_W-1:0]   s2_r, s2_nxt;
  logic [ID_W-1:0]   val_r, val_nxt;
  logic [ID_W-1:0]   q_r, q_nxt;
  logic [BIT_W-1:0]  rem_r, rem_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  logic [ID_W-1:0]   mixed;
  logic [ID_W-1:0]   mod_src;
  logic [2*ID_W-1:0] prod;
  logic [ID_W-1:0]   byte_idx;
  logic              in_range;
  logic [7:0]        mask;
  logic [7:0]        rdata;
  logic              bit_new;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;

  assign mixed   = prev_r ^ (s1_r + s2_r);
  assign mod_src = cmd.sel_edge ? mixed : id_r;
  // reciprocal multiply gives the quotient estimate
  assign prod    = (2*ID_W)'(val_r) * (2*ID_W)'(RECIP);

  assign byte_idx = ID_W'(rem_r >> 3);
  assign in_range = byte_idx < ID_W'(BITMAP_BYTES);
  assign mask     = 8'(1) << rem_r[2:0];
  assign bit_new  = in_range && ((rdata & mask) == 8'd0);

  always_comb begin
    id_nxt       = id_r;
    prev_nxt     = prev_r;
    s1_nxt       = s1_r;
    s2_nxt       = s2_r;
    val_nxt      = val_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    mcnt_nxt     = mcnt_r;
    clr_addr_nxt = clr_addr_r;
    count_nxt    = count_r;
    ram_we       = 1'b0;
    ram_waddr    = byte_idx[AW-1:0];
    ram_wdata    = rdata | mask;

    if (cmd.load_id) begin
      id_nxt = in_hit_id;
    end
    if (cmd.hash_sum) begin
      s1_nxt = id_r + GOLDEN_STEP;
      s2_nxt = {prev_r[ID_W-7:0], 6'd0} + {2'd0, prev_r[ID_W-1:2]};
    end
    if (cmd.mod_load) begin
      if (cmd.sel_edge) begin
        prev_nxt = id_r;
      end
      if (POW2) begin
        rem_nxt  = mod_src[BIT_W-1:0];
        mcnt_nxt = '0;
      end else begin
        val_nxt  = mod_src;
        rem_nxt  = '0;
        mcnt_nxt = STEP_MUL;
      end
    end
    if (cmd.mod_step) begin
      mcnt_nxt = mcnt_r - 1'b1;
      case (mcnt_r)
        STEP_MUL: begin
          q_nxt = prod[2*ID_W-1:ID_W];
        end
        STEP_SUB: begin
          val_nxt = val_r - q_r * ID_W'(BITMAP_BITS);
        end
        STEP_FIX: begin
          if (val_r >= ID_W'(BITMAP_BITS)) begin
            rem_nxt = BIT_W'(val_r - ID_W'(BITMAP_BITS));
          end else begin
            rem_nxt = val_r[BIT_W-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.wr_bit && bit_new) begin
      ram_we    = 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.clr_start) begin
      clr_addr_nxt = '0;
      count_nxt    = '0;
    end
    if (cmd.clr_step) begin
      ram_we       = 1'b1;
      ram_waddr    = clr_addr_r;
      ram_wdata    = 8'd0;
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      mcnt_r     <= '0;
      clr_addr_r <= '0;
      count_r    <= '0;
    end else begin
      prev_r     <= prev_nxt;
      mcnt_r     <= mcnt_nxt;
      clr_addr_r <= clr_addr_nxt;
      count_r    <= count_nxt;
    end
    id_r  <= id_nxt;
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    val_r <= val_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  cbr_ram #(
    .WIDTH(8),
    .DEPTH(BITMAP_BYTES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(byte_idx[AW-1:0]),
    .rdata(rdata)
  );

  assign status.mod_done = (mcnt_r == '0);
  assign status.clr_last = (clr_addr_r == AW'(BITMAP_BYTES - 1));

  // saturate at the largest 17-bit value
  assign out_bit_count = (32'(count_r) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_r);

endmodule

// ===== sv/cbr_ctrl.sv =====
// controller: sequences hits, clears and counts over the datapath
module cbr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cbr_pkg::OP_W-1:0]  in_op,
  input  cbr_pkg::cbr_status_t      status,
  output cbr_pkg::cbr_cmd_t         cmd,
  output logic                      busy,
  output logic                      out_valid
);

  import cbr_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HASH,
    S_LOAD,
    S_MOD,
    S_CHECK
  } state_t;

  state_t          state_r;
  logic [OP_W-1:0] op_r;
  logic            reply_r;
  logic            out_valid_r;
  logic            accept;

  assign accept = start && (state_r == S_IDLE) && rst_n;
  assign busy   = (state_r != S_IDLE) || !rst_n;

  always_comb begin
    cmd          = '0;
    cmd.sel_edge = (op_r == OP_EDGE);
    case (state_r)
      S_SWEEP: cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.load_id   = accept;
        cmd.clr_start = accept && (in_op == OP_CLEAR);
      end
      S_HASH:  cmd.hash_sum = 1'b1;
      S_LOAD:  cmd.mod_load = 1'b1;
      S_MOD: begin
        cmd.mod_step = !status.mod_done;
        cmd.rd_en    = status.mod_done;
      end
      S_CHECK: cmd.wr_bit = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_DIRECT;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_SWEEP: begin
          if (status.clr_last) begin
            state_r     <= S_IDLE;
            out_valid_r <= reply_r;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r <= in_op;
            case (in_op)
              OP_DIRECT: state_r <= S_LOAD;
              OP_EDGE:   state_r <= S_HASH;
              OP_CLEAR: begin
                state_r <= S_SWEEP;
                reply_r <= 1'b1;
              end
              default:   out_valid_r <= 1'b1;
            endcase
          end
        end
        S_HASH:  state_r <= S_LOAD;
        S_LOAD:  state_r <= S_MOD;
        S_MOD: begin
          if (status.mod_done) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/coverage_bitmap_recorder.sv =====
// top level: coverage bitmap recorder
// A word is taken when start is high and busy is low, and every word gives one
// result: out_valid pulses for one cycle with out_bit_count, the number of set
// bits after the operation, and the receiver must take it then. A direct hit
// passes the load, reduce and check states and an edge hit adds a hash state
// first; a hit does one read-modify-write of the byte-wide map ram, reading
// the byte as the reduction ends and setting the bit in the check state, and
// the result shows as busy drops. If BITMAP_BITS is not a power of two the
// index reduction is done by a reciprocal multiply, a subtract and one
// correction step. A count answers in the next cycle. A clear zeroes the map
// one byte a cycle and answers once the last byte is zeroed. After reset the
// same pass runs with busy high before the first word is taken.
module coverage_bitmap_recorder #(
  parameter int unsigned BITMAP_BITS  = cbr_pkg::BITMAP_BITS_DEF,
  parameter int unsigned BITMAP_BYTES = cbr_pkg::BITMAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cbr_pkg::OP_W-1:0]     in_op,
  input  logic [cbr_pkg::ID_W-1:0]     in_hit_id,
  output logic                         out_valid,
  output logic [cbr_pkg::COUNT_W-1:0]  out_bit_count
);

  import cbr_pkg::*;

  cbr_cmd_t    cmd;
  cbr_status_t status;

  cbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_op    (in_op),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  cbr_dp #(
    .BITMAP_BITS (BITMAP_BITS),
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_hit_id    (in_hit_id),
    .cmd          (cmd),
    .status       (status),
    .out_bit_count(out_bit_count)
  );

endmodule
